// ----- hdl/dfe_pkg.sv -----
// Shared types, constants and helpers for the decimal field extractor.
package dfe_pkg;

  localparam int MAX_AFFIX_LEN = 8;
  localparam int FREE_DIGITS   = 10;

  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_MINUS = 8'h2d;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [35:0] POS_MAX  = 36'h0_7fff_ffff;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_PREFIX = 5'b00010,
    PH_SKIP   = 5'b00100,
    PH_FIELD  = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    REG_PREFIX_CHARS = 3'd0,
    REG_PREFIX_COUNT = 3'd1,
    REG_SUFFIX_CHARS = 3'd2,
    REG_SUFFIX_COUNT = 3'd3,
    REG_SKIP_COUNT   = 3'd4,
    REG_FIELD_LENGTH = 3'd5
  } cfg_reg_t;

  function automatic logic [3:0] affix_len(input logic [3:0] n);
    return (n > 4'(MAX_AFFIX_LEN)) ? 4'(MAX_AFFIX_LEN) : n;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Newest byte sits in the low byte of recent; text holds its first char low.
  function automatic logic win_match(input logic [63:0] recent, input logic [63:0] text,
                                     input logic [3:0] n);
    logic       hit;
    logic [3:0] age;
    hit = 1'b1;
    for (int i = 0; i < MAX_AFFIX_LEN; i++) begin
      age = n - 4'(i) - 4'd1;
      if (4'(i) < n) begin
        if (recent[8*age[2:0] +: 8] != text[8*i +: 8]) begin
          hit = 1'b0;
        end
      end
    end
    return hit;
  endfunction

endpackage

// ----- hdl/decimal_field_extractor.sv -----
// Decimal field extractor: byte-serial prefix/skip/suffix signed integer parser.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------
//   input    | in_valid / in_stall    | ch
//   result   | out_valid / out_stall  | ok, number
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; the parse state updates in the cycle of the transfer.
// A zero byte loads the result register, seen on the next cycle.
// in_stall is raised only while a result waits and out_stall is high.
// cfg_ready is always high. Reset is synchronous and clears state, config and out_valid, but not ok or number.
module decimal_field_extractor (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         ch,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ok,
  output logic signed [31:0] number,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] prefix_chars;
  logic [3:0]  prefix_count;
  logic [63:0] suffix_chars;
  logic [3:0]  suffix_count;
  logic [7:0]  skip_count;
  logic [7:0]  field_length;

  dfe_pkg::phase_t phase, phase_next;
  logic [63:0] recent, recent_next;
  logic [3:0]  fill, fill_next;
  logic [7:0]  skip_left, skip_left_next;
  logic [7:0]  digits, digits_next;
  logic [31:0] accum, accum_next;
  logic        too_big, too_big_next;
  logic        neg, neg_next;
  logic        failed, failed_next;

  logic        in_xfer;
  logic        fire;
  logic        res_ok;
  logic [31:0] res_number;
  logic [3:0]  p_len;
  logic [3:0]  s_len;
  logic        tb_en;
  logic [7:0]  tb_byte;
  logic        dig_en;
  logic [3:0]  dig_val;
  logic [35:0] prod;
  logic        fl;
  logic        at_field;
  logic        bad_phase;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_xfer   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_chars <= '0;
      prefix_count <= '0;
      suffix_chars <= '0;
      suffix_count <= '0;
      skip_count   <= '0;
      field_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dfe_pkg::cfg_reg_t'(cfg_index))
        dfe_pkg::REG_PREFIX_CHARS: prefix_chars <= cfg_data;
        dfe_pkg::REG_PREFIX_COUNT: prefix_count <= cfg_data[3:0];
        dfe_pkg::REG_SUFFIX_CHARS: suffix_chars <= cfg_data;
        dfe_pkg::REG_SUFFIX_COUNT: suffix_count <= cfg_data[3:0];
        dfe_pkg::REG_SKIP_COUNT:   skip_count   <= cfg_data[7:0];
        dfe_pkg::REG_FIELD_LENGTH: field_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    p_len          = dfe_pkg::affix_len(prefix_count);
    s_len          = dfe_pkg::affix_len(suffix_count);
    phase_next     = phase;
    recent_next    = recent;
    fill_next      = fill;
    skip_left_next = skip_left;
    digits_next    = digits;
    accum_next     = accum;
    too_big_next   = too_big;
    neg_next       = neg;
    failed_next    = failed;
    fire           = 1'b0;
    res_ok         = 1'b0;
    res_number     = '0;
    tb_en          = 1'b0;
    tb_byte        = ch;
    dig_en         = 1'b0;
    dig_val        = '0;
    prod           = '0;
    fl             = failed;
    at_field       = (phase == dfe_pkg::PH_FIELD);
    bad_phase      = 1'b0;

    if (ch != dfe_pkg::CH_NUL) begin
      if (!(failed || phase == dfe_pkg::PH_DONE)) begin
        if (phase_next == dfe_pkg::PH_START) begin
          if (p_len == 4'd0) begin
            skip_left_next = skip_count;
            if (skip_count == 8'd0) begin
              recent_next  = '0;
              fill_next    = '0;
              digits_next  = '0;
              accum_next   = '0;
              too_big_next = 1'b0;
              neg_next     = 1'b0;
              phase_next   = dfe_pkg::PH_FIELD;
            end else begin
              phase_next = dfe_pkg::PH_SKIP;
            end
          end else begin
            recent_next = '0;
            fill_next   = '0;
            phase_next  = dfe_pkg::PH_PREFIX;
          end
        end

        if (phase_next == dfe_pkg::PH_PREFIX) begin
          recent_next = {recent_next[55:0], ch};
          if (fill_next < 4'(dfe_pkg::MAX_AFFIX_LEN)) begin
            fill_next = fill_next + 4'd1;
          end
          if (p_len == 4'd0 || (fill_next >= p_len &&
              dfe_pkg::win_match(recent_next, prefix_chars, p_len))) begin
            skip_left_next = skip_count;
            if (skip_count == 8'd0) begin
              recent_next  = '0;
              fill_next    = '0;
              digits_next  = '0;
              accum_next   = '0;
              too_big_next = 1'b0;
              neg_next     = 1'b0;
              phase_next   = dfe_pkg::PH_FIELD;
            end else begin
              phase_next = dfe_pkg::PH_SKIP;
            end
          end
        end else if (phase_next == dfe_pkg::PH_SKIP) begin
          if (skip_left_next != 8'd0) begin
            skip_left_next = skip_left_next - 8'd1;
          end
          if (skip_left_next == 8'd0) begin
            recent_next  = '0;
            fill_next    = '0;
            digits_next  = '0;
            accum_next   = '0;
            too_big_next = 1'b0;
            neg_next     = 1'b0;
            phase_next   = dfe_pkg::PH_FIELD;
          end
        end else if (phase_next == dfe_pkg::PH_FIELD) begin
          if (s_len != 4'd0) begin
            tb_en   = (fill_next >= s_len);
            tb_byte = recent_next[8*s_len - 8 +: 8];
          end else if (field_length != 8'd0) begin
            tb_en   = 1'b1;
            tb_byte = ch;
          end

          // bounded field byte
          if (tb_en) begin
            if (digits_next == 8'd0 && tb_byte == dfe_pkg::CH_MINUS) begin
              neg_next = 1'b1;
            end else if (!dfe_pkg::is_digit(tb_byte)) begin
              failed_next = 1'b1;
            end else begin
              dig_en  = 1'b1;
              dig_val = tb_byte[3:0];
            end
            if (digits_next != 8'hff) begin
              digits_next = digits_next + 8'd1;
            end
          end

          if (s_len != 4'd0) begin
            recent_next = {recent_next[55:0], ch};
            if (fill_next < s_len) begin
              fill_next = fill_next + 4'd1;
            end
            if (fill_next >= s_len && dfe_pkg::win_match(recent_next, suffix_chars, s_len)) begin
              if (digits_next == 8'd0) begin
                failed_next = 1'b1;
              end else begin
                phase_next = dfe_pkg::PH_DONE;
              end
            end
          end else if (field_length != 8'd0) begin
            if (digits_next >= field_length) begin
              phase_next = dfe_pkg::PH_DONE;
            end
          end else begin
            // free mode
            if (digits_next == 8'd0 && ch == dfe_pkg::CH_MINUS) begin
              neg_next    = 1'b1;
              digits_next = 8'd1;
            end else if (!dfe_pkg::is_digit(ch)) begin
              phase_next = dfe_pkg::PH_DONE;
            end else begin
              dig_en      = 1'b1;
              dig_val     = ch[3:0];
              digits_next = digits_next + 8'd1;
              if ((digits_next - {7'd0, neg_next}) >= 8'(dfe_pkg::FREE_DIGITS)) begin
                phase_next = dfe_pkg::PH_DONE;
              end
            end
          end
        end

        if (dig_en) begin
          prod = ({4'd0, accum_next} << 3) + ({4'd0, accum_next} << 1) + {32'd0, dig_val};
          if (prod > dfe_pkg::POS_MAX) begin
            too_big_next = 1'b1;
          end
          accum_next = prod[31:0];
        end
      end
    end else begin
      fire = 1'b1;
      if (phase == dfe_pkg::PH_START && !failed) begin
        if (p_len == 4'd0 && skip_count == 8'd0) begin
          at_field = 1'b1;
        end else begin
          fl = 1'b1;
        end
      end
      bad_phase = (phase == dfe_pkg::PH_PREFIX) || (phase == dfe_pkg::PH_SKIP) ||
                  (phase == dfe_pkg::PH_START && !at_field);
      res_ok = !fl && !bad_phase &&
               !(at_field && (s_len != 4'd0 || field_length != 8'd0)) &&
               !(too_big && !neg);
      if (res_ok) begin
        res_number = neg ? (32'd0 - accum) : accum;
      end
      phase_next     = dfe_pkg::PH_START;
      recent_next    = '0;
      fill_next      = '0;
      skip_left_next = '0;
      digits_next    = '0;
      accum_next     = '0;
      too_big_next   = 1'b0;
      neg_next       = 1'b0;
      failed_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= dfe_pkg::PH_START;
      recent    <= '0;
      fill      <= '0;
      skip_left <= '0;
      digits    <= '0;
      accum     <= '0;
      too_big   <= 1'b0;
      neg       <= 1'b0;
      failed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase     <= phase_next;
        recent    <= recent_next;
        fill      <= fill_next;
        skip_left <= skip_left_next;
        digits    <= digits_next;
        accum     <= accum_next;
        too_big   <= too_big_next;
        neg       <= neg_next;
        failed    <= failed_next;
      end
      if (in_xfer && fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && fire) begin
      ok     <= res_ok;
      number <= res_number;
    end
  end

endmodule

// ----- hdl/dfe_checker.sv -----
// Port-level checks for the decimal field extractor, bound to the top level.
module dfe_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         ch,
  input logic               out_valid,
  input logic               out_stall,
  input logic               ok,
  input logic signed [31:0] number
);

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> number == 32'sd0)
    else $error("failed result carries a nonzero number");

  a_new_from_nul: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid && out_stall) |->
      $past(in_valid && !in_stall && ch == dfe_pkg::CH_NUL))
    else $error("result transfer without a terminator");

  a_byte_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && ch != dfe_pkg::CH_NUL |=> !out_valid)
    else $error("non-terminator byte produced a result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ok) && $stable(number))
    else $error("stalled result changed");

endmodule

bind decimal_field_extractor dfe_checker u_dfe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .ch        (ch),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .ok        (ok),
  .number    (number)
);
